FILE: hdl/hcsp_pkg.sv
// Shared types, constants and helpers for the hex color spec parser.
// Has no dependencies. Used by hcsp_accum, hcsp_format, the top level and the checker.
package hcsp_pkg;

  localparam int unsigned CH_W     = 8;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned STORE_W  = 48;
  localparam int unsigned COLOR_W  = 16;
  localparam int unsigned STATUS_W = 2;

  localparam logic [CH_W-1:0] CH_HASH = 8'h23;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;
  localparam logic [COUNT_W-1:0] LEN_1D    = 4'd4;
  localparam logic [COUNT_W-1:0] LEN_2D    = 4'd7;
  localparam logic [COUNT_W-1:0] LEN_3D    = 4'd10;
  localparam logic [COUNT_W-1:0] LEN_4D    = 4'd13;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_NAMED     = 2'd2
  } status_t;

  // Parse state carried between characters of one spec.
  typedef struct packed {
    logic [COUNT_W-1:0] char_count;
    logic [STORE_W-1:0] digit_store;
    logic               bad_digit;
    logic               not_hash;
  } parse_state_t;

  // Hex digit decode: bit 4 set when the character is a hex digit.
  function automatic logic [4:0] hex_decode(input logic [CH_W-1:0] c);
    logic [4:0] res;
    res = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      res = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      res = {1'b1, c[3:0] + 4'd9};
    end
    return res;
  endfunction

endpackage

FILE: hdl/hcsp_accum.sv
// Per-character parse state: count, digit store and error flags.
// Depends on hcsp_pkg.
module hcsp_accum import hcsp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [CH_W-1:0]    ch,
  input  logic               last,
  output parse_state_t       upd
);

  parse_state_t state_r;
  parse_state_t state_nxt;
  logic [4:0]   hex;

  assign hex = hex_decode(ch);

  // Fold the current character into the state.
  always_comb begin
    upd = state_r;
    if (state_r.char_count == '0) begin
      upd.not_hash = (ch != CH_HASH);
    end else if (hex[4]) begin
      upd.digit_store = {state_r.digit_store[STORE_W-5:0], hex[3:0]};
    end else begin
      upd.bad_digit = 1'b1;
    end
    if (state_r.char_count != COUNT_MAX) begin
      upd.char_count = state_r.char_count + 4'd1;
    end
  end

  // Clear after the final character of a spec.
  always_comb begin
    state_nxt = state_r;
    if (step) begin
      state_nxt = last ? '0 : upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/hcsp_format.sv
// Turns a finished parse state into scaled red, green, blue and a status.
// Depends on hcsp_pkg. Purely combinational.
module hcsp_format import hcsp_pkg::*; (
  input  parse_state_t         st,
  output logic [COLOR_W-1:0]   red,
  output logic [COLOR_W-1:0]   green,
  output logic [COLOR_W-1:0]   blue,
  output status_t              status
);

  logic [STORE_W-1:0] s;

  assign s = st.digit_store;

  always_comb begin
    red    = '0;
    green  = '0;
    blue   = '0;
    status = ST_OK;
    if (st.not_hash) begin
      status = ST_NAMED;
    end else if (st.bad_digit) begin
      status = ST_MALFORMED;
    end else begin
      case (st.char_count)
        LEN_1D: begin
          red   = {s[11:8], s[11:8], 8'h00};
          green = {s[7:4],  s[7:4],  8'h00};
          blue  = {s[3:0],  s[3:0],  8'h00};
        end
        LEN_2D: begin
          red   = {s[23:16], 8'h00};
          green = {s[15:8],  8'h00};
          blue  = {s[7:0],   8'h00};
        end
        LEN_3D: begin
          red   = {s[35:24], 4'h0};
          green = {s[23:12], 4'h0};
          blue  = {s[11:0],  4'h0};
        end
        LEN_4D: begin
          red   = s[47:32];
          green = s[31:16];
          blue  = s[15:0];
        end
        default: begin
          status = ST_MALFORMED;
        end
      endcase
    end
  end

endmodule

FILE: hdl/hex_color_spec_parser_unit.sv
// Top level of the hex color spec parser: input register, parse state, result register.
// Depends on hcsp_pkg, hcsp_accum and hcsp_format.
//
//   channel | signals                                   | word
//   --------+-------------------------------------------+-----------------------------
//   in      | in_valid, in_ready, in_ch, in_last        | one character, last flagged
//   out     | out_valid, out_ready, out_red, out_green, | one color per spec
//           | out_blue, out_status                      |
//
// One character is taken every cycle while no final character is held back. The
// character sits in the input register while the parse state folds it in; when the
// final character advances, the scaled color loads the result register and out_valid
// rises with it. Reset (rst_n low, synchronous) empties both registers and clears the
// parse state. A stalled result holds back a final character waiting in the input
// register, and with it the input; other characters keep flowing.
module hex_color_spec_parser_unit import hcsp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CH_W-1:0]     in_ch,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COLOR_W-1:0]  out_red,
  output logic [COLOR_W-1:0]  out_green,
  output logic [COLOR_W-1:0]  out_blue,
  output logic [STATUS_W-1:0] out_status
);

  // Input register.
  logic            in_vld_r, in_vld_nxt;
  logic [CH_W-1:0] ch_r;
  logic            last_r;

  // Result register.
  logic               out_vld_r, out_vld_nxt;
  logic [COLOR_W-1:0] red_r, green_r, blue_r;
  status_t            status_r;

  parse_state_t       upd;
  logic [COLOR_W-1:0] red_c, green_c, blue_c;
  status_t            status_c;

  logic out_free;
  logic advance;
  logic load_res;

  // The result register is free when empty or being drained this cycle.
  assign out_free = !out_vld_r || out_ready;
  // Advance the held character unless it is final and the result slot is full and not draining.
  assign advance  = in_vld_r && (!last_r || out_free);
  assign load_res = advance && last_r;
  assign in_ready = !in_vld_r || advance;

  hcsp_accum u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .ch    (ch_r),
    .last  (last_r),
    .upd   (upd)
  );

  hcsp_format u_format (
    .st     (upd),
    .red    (red_c),
    .green  (green_c),
    .blue   (blue_c),
    .status (status_c)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_ready) begin
      in_vld_nxt = in_valid;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (load_res) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers: capture on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ch_r   <= in_ch;
      last_r <= in_last;
    end
    if (load_res) begin
      red_r    <= red_c;
      green_r  <= green_c;
      blue_r   <= blue_c;
      status_r <= status_c;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_red    = red_r;
  assign out_green  = green_r;
  assign out_blue   = blue_r;
  assign out_status = status_r;

endmodule

FILE: hdl/hcsp_checker.sv
// Port-level checks for hex_color_spec_parser_unit, attached with a bind.
// Depends on hcsp_pkg and the top level.
module hcsp_checker import hcsp_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [CH_W-1:0]     in_ch,
  input logic                in_last,
  input logic                out_valid,
  input logic                out_ready,
  input logic [COLOR_W-1:0]  out_red,
  input logic [COLOR_W-1:0]  out_green,
  input logic [COLOR_W-1:0]  out_blue,
  input logic [STATUS_W-1:0] out_status
);

  // No result may appear right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result valid just after reset");

  // Any error status delivers black.
  a_err_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_red == '0 && out_green == '0 && out_blue == '0)
    else $error("non-zero color with error status");

  // With the result slot empty, input must never be stalled.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // A stalled result holds its word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) &&
      $stable(out_green) && $stable(out_blue) && $stable(out_status))
    else $error("stalled result changed");

  // A waiting character word holds until taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_ch) && $stable(in_last))
    else $error("waiting character changed");

endmodule

bind hex_color_spec_parser_unit hcsp_checker u_hcsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .in_ch      (in_ch),
  .in_last    (in_last),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_red    (out_red),
  .out_green  (out_green),
  .out_blue   (out_blue),
  .out_status (out_status)
);

FILE: test/tb.sv
`timescale 1ns / 100ps
// Testbench for hex_color_spec_parser_unit: streams color specs one character per word and
// checks every color word against a built-in prediction. Depends on hcsp_pkg and the RTL.

module tb import hcsp_pkg::*; ;

  localparam int unsigned RUN_LIMIT  = 300000;
  localparam int unsigned PHASE_CHARS = 420;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
  } char_word_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    status_t            status;
  } color_word_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CH_W-1:0]     in_ch = '0;
  logic                in_last = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [COLOR_W-1:0]  out_red;
  logic [COLOR_W-1:0]  out_green;
  logic [COLOR_W-1:0]  out_blue;
  logic [STATUS_W-1:0] out_status;

  // Characters waiting to be offered, and colors waiting to come out.
  char_word_t  pending_chars[$];
  color_word_t expected_colors[$];
  byte unsigned spec_buf[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned chars_queued = 0;
  int unsigned chars_taken = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  logic        in_took = 1'b0;

  // Predicted parse state of the spec in flight.
  logic [COUNT_W-1:0] spec_len = '0;
  logic [STORE_W-1:0] spec_digits = '0;
  logic               spec_bad = 1'b0;
  logic               spec_named = 1'b0;

  string hex_set = "0123456789abcdefABCDEF";
  string junk_set = " +-#xX";

  hex_color_spec_parser_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_ch      (in_ch),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_status (out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bit 4 flags a hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] digit_value(input logic [CH_W-1:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return 5'd0;
  endfunction

  // Widen one group of n digits to a 16-bit intensity.
  function automatic logic [COLOR_W-1:0] widen_group(input logic [15:0] g, input int n);
    case (n)
      1: return {g[3:0], g[3:0], 8'h00};
      2: return {g[7:0], 8'h00};
      3: return {g[11:0], 4'h0};
      default: return g;
    endcase
  endfunction

  // Fold one accepted character into the predicted state; on the final
  // character, queue the predicted color and clear the state.
  task automatic fold_char(input logic [CH_W-1:0] c, input logic fin);
    logic [4:0]         dv;
    color_word_t        col;
    int                 n;
    logic [STORE_W-1:0] grp_mask;
    if (spec_len == 0) begin
      spec_named = (c != CH_HASH);
    end else begin
      dv = digit_value(c);
      if (!dv[4]) spec_bad = 1'b1;
      else spec_digits = {spec_digits[STORE_W-5:0], dv[3:0]};
    end
    if (spec_len != COUNT_MAX) spec_len = spec_len + 1'b1;
    if (fin) begin
      col = '{red: '0, green: '0, blue: '0, status: ST_OK};
      if (spec_named) begin
        col.status = ST_NAMED;
      end else if (spec_bad || !(spec_len inside {LEN_1D, LEN_2D, LEN_3D, LEN_4D})) begin
        col.status = ST_MALFORMED;
      end else begin
        n = (int'(spec_len) - 1) / 3;
        grp_mask = (48'h1 << (4 * n)) - 1;
        col.red   = widen_group(16'((spec_digits >> (8 * n)) & grp_mask), n);
        col.green = widen_group(16'((spec_digits >> (4 * n)) & grp_mask), n);
        col.blue  = widen_group(16'(spec_digits & grp_mask), n);
      end
      expected_colors.push_back(col);
      spec_len = '0;
      spec_digits = '0;
      spec_bad = 1'b0;
      spec_named = 1'b0;
    end
  endtask

  task automatic log_mismatch(input string field, input logic [15:0] got,
                              input logic [15:0] want);
    $display("t=%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    mismatches++;
  endtask

  // Monitor: sample both channels at the rising edge. Fold in the accepted
  // character word, then check the accepted color word against the oldest one.
  always @(posedge clk) begin
    if (rst_n) begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        fold_char(in_ch, in_last);
        chars_taken <= chars_taken + 1;
      end
      if (out_valid && out_ready) begin
        if (expected_colors.size() == 0) begin
          log_mismatch("unexpected color word", out_red, 16'h0);
        end else begin
          if (out_red !== expected_colors[0].red)
            log_mismatch("red", out_red, expected_colors[0].red);
          if (out_green !== expected_colors[0].green)
            log_mismatch("green", out_green, expected_colors[0].green);
          if (out_blue !== expected_colors[0].blue)
            log_mismatch("blue", out_blue, expected_colors[0].blue);
          if (out_status !== expected_colors[0].status)
            log_mismatch("status", 16'(out_status), 16'(expected_colors[0].status));
          void'(expected_colors.pop_front());
        end
      end
    end else begin
      in_took <= 1'b0;
    end
  end

  // Driver: at the falling edge, advance to the next character word once the
  // current one was taken, or go idle at random. Hold valid and payload otherwise.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_ch    <= pending_chars[0].ch;
        in_last  <= pending_chars[0].last;
        void'(pending_chars.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random, or hold off for a long stretch when asked,
  // counting the stretch down here.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: fail the run if it never drains.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Move the scratch spec into the pending queue, flagging its final character.
  task automatic flush_spec();
    foreach (spec_buf[i])
      pending_chars.push_back('{ch: spec_buf[i], last: (i == spec_buf.size() - 1)});
    chars_queued += spec_buf.size();
    spec_buf.delete();
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) spec_buf.push_back(s[i]);
    flush_spec();
  endtask

  function automatic byte unsigned any_hex();
    return hex_set[$urandom_range(hex_set.len() - 1)];
  endfunction

  // Build one random spec: mostly well-formed with random digits, the rest
  // named colors, wrong lengths (a few past saturation) and corrupted digits.
  task automatic queue_random_spec();
    int kind;
    int n;
    int k;
    byte unsigned first_ch;
    kind = $urandom_range(99);
    if (kind < 72) begin
      n = $urandom_range(1, 4);
      spec_buf.push_back(CH_HASH);
      repeat (3 * n) spec_buf.push_back(any_hex());
    end else if (kind < 80) begin
      n = $urandom_range(1, 8);
      do first_ch = 8'($urandom_range(255));
      while (first_ch == CH_HASH);
      spec_buf.push_back(first_ch);
      while (spec_buf.size() < n) spec_buf.push_back(8'($urandom_range(255)));
    end else if (kind < 90) begin
      do k = ($urandom_range(9) == 0) ? $urandom_range(13, 19) : $urandom_range(0, 14);
      while (k == 3 || k == 6 || k == 9 || k == 12);
      spec_buf.push_back(CH_HASH);
      repeat (k) spec_buf.push_back(any_hex());
    end else begin
      n = $urandom_range(1, 4);
      spec_buf.push_back(CH_HASH);
      repeat (3 * n) spec_buf.push_back(any_hex());
      k = $urandom_range(1, 3 * n);
      spec_buf[k] = ($urandom_range(1) == 0) ? 8'($urandom_range(255))
                                              : junk_set[$urandom_range(5)];
    end
    flush_spec();
  endtask

  task automatic queue_random_chars(input int unsigned count);
    int unsigned goal;
    goal = chars_queued + count;
    while (chars_queued < goal) queue_random_spec();
  endtask

  // Hold the test sequence until every queued word was taken and every color came out.
  task automatic drain();
    do @(negedge clk);
    while (chars_taken != chars_queued || expected_colors.size() != 0);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed specs, no idling: one- and two-digit scales, mixed case, lone hash, named
    // colors (one character, leading NUL), NUL/0xFF/space/0x/second hash.
    @(posedge clk);
    queue_text("#aF9");
    queue_text("#0A0b0C");
    queue_text("#");
    queue_text("Z");
    spec_buf = '{8'h00, CH_HASH};
    flush_spec();
    spec_buf = '{CH_HASH, 8'h00, 8'hFF, " "};
    flush_spec();
    queue_text("#0x#");
    queue_random_chars(PHASE_CHARS);
    drain();

    set_idling(57, 0);
    queue_random_chars(PHASE_CHARS);
    drain();

    set_idling(0, 57);
    queue_random_chars(PHASE_CHARS);
    drain();

    set_idling(23, 23);
    queue_random_chars(PHASE_CHARS);
    drain();

    // Back-pressure: hold the receiver off while the sender keeps streaming,
    // so the result register fills and the input stalls on a final character.
    set_idling(0, 0);
    hold_req = hold_req + 1;
    repeat (60) begin
      if ($urandom_range(1) == 0) queue_text("q");
      else queue_random_spec();
    end
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
